// ===== src/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and codes for the wire-format field decoder.
// ----------------------------------------------------------------------------
package pfd_pkg;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW = 1;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_VALUE,
		PH_FIXED,
		PH_LENGTH,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SCALAR,
		KIND_HEADER,
		KIND_PAYLOAD,
		KIND_ERROR
	} kind_t;

	localparam logic [1:0] ERR_WIRE_TYPE = 2'd0;
	localparam logic [1:0] ERR_TRUNCATED = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG = 2'd2;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	localparam logic [3:0] VARINT_LAST = 4'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [28:0] field_id;
		logic [2:0]  wire_fmt;
		logic [63:0] value;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [1:0]  error_code;
	} out_word_t;

	typedef struct packed {
		kind_t       kind;
		logic        has_tag;
		logic [28:0] field_id;
		logic [2:0]  wire_fmt;
		logic [63:0] value;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [1:0]  error_code;
	} cmd_t;

endpackage

// ===== src/pfd_front.sv =====
// ----------------------------------------------------------------------------
// pfd_front
// Byte-level decode: tracks the phase of the current field and turns each
// accepted byte into at most one result command.
// ----------------------------------------------------------------------------
module pfd_front import pfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_word_t in_word,
	output logic     push,
	output cmd_t     cmd
);

	phase_t      phase_q, phase_d;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [28:0] field_q, field_d;
	logic [2:0]  wt_q, wt_d;
	logic [63:0] rem_q, rem_d;

	logic [7:0]  b;
	logic        eob;
	logic [3:0]  k_v;
	logic [5:0]  sh7;
	logic [63:0] acc_v;
	logic [63:0] acc_f;
	logic [3:0]  cnt_f;
	logic [3:0]  n_f;
	logic [63:0] rem_dec;
	logic        cont;
	logic        v_long;
	logic        res_valid;

	always_comb begin
		b = in_word.data_byte;
		eob = in_word.end_of_buffer;
		k_v = (cnt_q > VARINT_LAST) ? VARINT_LAST : cnt_q;
		sh7 = 6'(7 * k_v);
		acc_v = acc_q | ({57'd0, b[6:0]} << sh7);
		acc_f = acc_q | ({56'd0, b} << {cnt_q[2:0], 3'b000});
		cnt_f = {1'b0, cnt_q[2:0]} + 4'd1;
		n_f = (wt_q == WT_FIXED64) ? 4'd8 : 4'd4;
		rem_dec = (rem_q != 64'd0) ? rem_q - 64'd1 : 64'd0;
		cont = b[7];
		v_long = cont && (k_v == VARINT_LAST);

		phase_d = phase_q;
		acc_d = acc_q;
		cnt_d = cnt_q;
		field_d = field_q;
		wt_d = wt_q;
		rem_d = rem_q;
		res_valid = 1'b0;
		cmd.kind = KIND_ERROR;
		cmd.has_tag = 1'b1;
		cmd.field_id = field_q;
		cmd.wire_fmt = wt_q;
		cmd.value = acc_v;
		cmd.payload_byte = b;
		cmd.payload_last = 1'b0;
		cmd.error_code = ERR_TRUNCATED;

		unique case (phase_q)
			PH_VALUE, PH_LENGTH: begin
				if (v_long) begin
					res_valid = 1'b1;
					cmd.error_code = ERR_TOO_LONG;
					phase_d = PH_TAG;
					acc_d = '0;
					cnt_d = '0;
				end else if (cont) begin
					acc_d = acc_v;
					cnt_d = k_v + 4'd1;
					if (eob) begin
						res_valid = 1'b1;
						phase_d = PH_TAG;
						acc_d = '0;
						cnt_d = '0;
					end
				end else begin
					res_valid = 1'b1;
					acc_d = '0;
					cnt_d = '0;
					if (phase_q == PH_VALUE) begin
						cmd.kind = KIND_SCALAR;
						phase_d = PH_TAG;
					end else if (acc_v == 64'd0) begin
						cmd.kind = KIND_HEADER;
						phase_d = PH_TAG;
					end else if (eob) begin
						phase_d = PH_TAG;
					end else begin
						cmd.kind = KIND_HEADER;
						rem_d = acc_v;
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_FIXED: begin
				cmd.value = acc_f;
				acc_d = acc_f;
				cnt_d = cnt_f;
				if (cnt_f >= n_f) begin
					res_valid = 1'b1;
					cmd.kind = KIND_SCALAR;
					phase_d = PH_TAG;
					acc_d = '0;
					cnt_d = '0;
				end else if (eob) begin
					res_valid = 1'b1;
					phase_d = PH_TAG;
					acc_d = '0;
					cnt_d = '0;
				end
			end
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				rem_d = rem_dec;
				if (rem_dec == 64'd0) begin
					cmd.kind = KIND_PAYLOAD;
					cmd.payload_last = 1'b1;
					phase_d = PH_TAG;
					acc_d = '0;
					cnt_d = '0;
				end else if (eob) begin
					phase_d = PH_TAG;
					acc_d = '0;
					cnt_d = '0;
				end else begin
					cmd.kind = KIND_PAYLOAD;
				end
			end
			default: begin
				cmd.has_tag = 1'b0;
				if (v_long) begin
					res_valid = 1'b1;
					cmd.error_code = ERR_TOO_LONG;
					phase_d = PH_TAG;
					acc_d = '0;
					cnt_d = '0;
				end else if (cont) begin
					acc_d = acc_v;
					cnt_d = k_v + 4'd1;
					if (eob) begin
						res_valid = 1'b1;
						phase_d = PH_TAG;
						acc_d = '0;
						cnt_d = '0;
					end
				end else begin
					field_d = acc_v[31:3];
					wt_d = acc_v[2:0];
					acc_d = '0;
					cnt_d = '0;
					cmd.has_tag = 1'b1;
					cmd.field_id = acc_v[31:3];
					cmd.wire_fmt = acc_v[2:0];
					if (acc_v[2:0] != WT_VARINT && acc_v[2:0] != WT_FIXED64 &&
					    acc_v[2:0] != WT_LEN && acc_v[2:0] != WT_FIXED32) begin
						res_valid = 1'b1;
						cmd.error_code = ERR_WIRE_TYPE;
						phase_d = PH_TAG;
					end else if (eob) begin
						res_valid = 1'b1;
						phase_d = PH_TAG;
					end else if (acc_v[2:0] == WT_VARINT) begin
						phase_d = PH_VALUE;
					end else if (acc_v[2:0] == WT_LEN) begin
						phase_d = PH_LENGTH;
					end else begin
						phase_d = PH_FIXED;
					end
				end
			end
		endcase

		push = accept && res_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			acc_q <= '0;
			cnt_q <= '0;
			field_q <= '0;
			wt_q <= '0;
			rem_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			field_q <= field_d;
			wt_q <= wt_d;
			rem_q <= rem_d;
		end
	end

endmodule

// ===== src/pfd_queue.sv =====
// ----------------------------------------------------------------------------
// pfd_queue
// Two-entry command queue between the decode front and the output stage.
// ----------------------------------------------------------------------------
module pfd_queue import pfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty,
	output logic full
);

	cmd_t              mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == (Q_AW + 1)'(Q_DEPTH));
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/pfd_back.sv =====
// ----------------------------------------------------------------------------
// pfd_back
// Output stage: formats a queued command into a result word and holds it
// until the receiver takes it.
// ----------------------------------------------------------------------------
module pfd_back import pfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  cmd_t      q_cmd,
	output logic      pop,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_word_t dst_word
);

	out_word_t word_d;
	out_word_t word_q;
	logic      valid_q;

	assign pop = !q_empty && (!valid_q || !dst_stall);
	assign dst_valid = valid_q;
	assign dst_word = word_q;

	always_comb begin
		word_d.kind = q_cmd.kind;
		word_d.field_id = q_cmd.has_tag ? q_cmd.field_id : '0;
		word_d.wire_fmt = q_cmd.has_tag ? q_cmd.wire_fmt : '0;
		word_d.value = '0;
		word_d.payload_byte = '0;
		word_d.payload_last = 1'b0;
		word_d.error_code = '0;
		unique case (q_cmd.kind)
			KIND_SCALAR, KIND_HEADER: begin
				word_d.value = q_cmd.value;
			end
			KIND_PAYLOAD: begin
				word_d.payload_byte = q_cmd.payload_byte;
				word_d.payload_last = q_cmd.payload_last;
			end
			KIND_ERROR: begin
				word_d.error_code = q_cmd.error_code;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!dst_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/protobuf_field_decoder_core.sv =====
// ----------------------------------------------------------------------------
// protobuf_field_decoder_core
// Wire-format field decoder: one encoded byte in, at most one result word out.
// ----------------------------------------------------------------------------
// Source channel src_*: one byte of the encoded buffer per word, with
// end_of_buffer set on the final byte. Destination channel dst_*: scalar
// fields, length-delimited headers, payload bytes and errors, one per word.
// Both channels take a word on a rising edge with valid high and stall low.
// Throughput is one byte per cycle while src_stall is low; a byte's result
// word is written into the queue as the byte is taken and reaches dst through
// the output register, which loads it when dst is not stalled.
// Bytes that complete no result produce nothing on dst.
// A two-entry queue sits between decode and output; src_stall rises only
// when that queue is full, i.e. while dst is stalled and results back up.
// A stalled dst word holds its value until taken.
// Reset clears the queue and output valid and puts decode in the tag phase.
// ----------------------------------------------------------------------------
module protobuf_field_decoder_core import pfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_word_t  src_word,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_word_t dst_word
);

	logic accept;
	logic push;
	logic pop;
	logic q_empty;
	logic q_full;
	cmd_t front_cmd;
	cmd_t head_cmd;

	assign src_stall = q_full;
	assign accept = src_valid && !q_full;

	pfd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_word (src_word),
		.push    (push),
		.cmd     (front_cmd)
	);

	pfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	pfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (head_cmd),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (dst_word)
	);

endmodule

// ===== sim/protobuf_field_decoder_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// protobuf_field_decoder_core_tb
// Feeds encoded buffers byte by byte into the decoder and checks each result
// word against a bit-exact decoder model kept in a small scoreboard. Short
// directed buffers come first, then random messages built from well-formed
// fields with random content, plus truncated buffers, bad wire types,
// overlong varints and raw noise. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module protobuf_field_decoder_core_tb;
	import pfd_pkg::*;

	class wire_decode_board;
		typedef enum {VI_MORE, VI_DONE, VI_LONG} varint_step_t;

		phase_t      phase;
		logic [63:0] acc;
		logic [3:0]  nbytes;
		logic [28:0] field_no;
		logic [2:0]  wtype;
		logic [63:0] remaining;
		out_word_t   due_words[$];
		int          mismatches;

		function new();
			phase = PH_TAG;
			acc = '0;
			nbytes = '0;
			field_no = '0;
			wtype = '0;
			remaining = '0;
			mismatches = 0;
		endfunction

		function void restart_tag();
			phase = PH_TAG;
			acc = '0;
			nbytes = '0;
		endfunction

		function varint_step_t varint_byte(logic [7:0] b);
			logic [3:0] k;
			k = (nbytes > VARINT_LAST) ? VARINT_LAST : nbytes;
			acc = acc | ({57'd0, b[6:0]} << (7 * k));
			if (!b[7])
				return VI_DONE;
			if (k == VARINT_LAST)
				return VI_LONG;
			nbytes = k + 4'd1;
			return VI_MORE;
		endfunction

		function out_word_t error_word(bit with_tag, logic [1:0] code);
			out_word_t w;
			w = '0;
			w.kind = KIND_ERROR;
			w.error_code = code;
			if (with_tag) begin
				w.field_id = field_no;
				w.wire_fmt = wtype;
			end
			restart_tag();
			return w;
		endfunction

		function out_word_t field_word(kind_t kind, logic [63:0] value, logic [7:0] pb,
				logic last);
			out_word_t w;
			w = '0;
			w.kind = kind;
			w.field_id = field_no;
			w.wire_fmt = wtype;
			w.value = value;
			w.payload_byte = pb;
			w.payload_last = last;
			return w;
		endfunction

		function bit decode_byte(in_word_t w, output out_word_t res);
			logic [7:0]   b;
			logic         eob;
			varint_step_t st;
			logic [63:0]  v;
			logic [2:0]   k;
			kind_t        kd;
			b = w.data_byte;
			eob = w.end_of_buffer;
			res = '0;
			case (phase)
			PH_VALUE, PH_LENGTH: begin
				st = varint_byte(b);
				if (st == VI_LONG) begin
					res = error_word(1'b1, ERR_TOO_LONG);
					return 1'b1;
				end
				if (st == VI_MORE) begin
					if (eob)
						res = error_word(1'b1, ERR_TRUNCATED);
					return eob;
				end
				v = acc;
				if (phase == PH_VALUE || v == 0) begin
					if (phase == PH_VALUE)
						kd = KIND_SCALAR;
					else
						kd = KIND_HEADER;
					res = field_word(kd, v, '0, 1'b0);
					restart_tag();
					return 1'b1;
				end
				if (eob) begin
					res = error_word(1'b1, ERR_TRUNCATED);
					return 1'b1;
				end
				acc = '0;
				nbytes = '0;
				remaining = v;
				phase = PH_PAYLOAD;
				res = field_word(KIND_HEADER, v, '0, 1'b0);
				return 1'b1;
			end
			PH_FIXED: begin
				k = nbytes[2:0];
				acc = acc | ({56'd0, b} << (8 * k));
				nbytes = {1'b0, k} + 4'd1;
				if (nbytes >= ((wtype == WT_FIXED64) ? 4'd8 : 4'd4)) begin
					res = field_word(KIND_SCALAR, acc, '0, 1'b0);
					restart_tag();
					return 1'b1;
				end
				if (eob)
					res = error_word(1'b1, ERR_TRUNCATED);
				return eob;
			end
			PH_PAYLOAD: begin
				if (remaining != 0)
					remaining = remaining - 64'd1;
				if (remaining == 0) begin
					res = field_word(KIND_PAYLOAD, '0, b, 1'b1);
					restart_tag();
					return 1'b1;
				end
				if (eob)
					res = error_word(1'b1, ERR_TRUNCATED);
				else
					res = field_word(KIND_PAYLOAD, '0, b, 1'b0);
				return 1'b1;
			end
			default: begin
				st = varint_byte(b);
				if (st == VI_LONG) begin
					res = error_word(1'b0, ERR_TOO_LONG);
					return 1'b1;
				end
				if (st == VI_MORE) begin
					if (eob)
						res = error_word(1'b0, ERR_TRUNCATED);
					return eob;
				end
				field_no = acc[31:3];
				wtype = acc[2:0];
				acc = '0;
				nbytes = '0;
				case (wtype)
				WT_VARINT: phase = PH_VALUE;
				WT_LEN: phase = PH_LENGTH;
				WT_FIXED64, WT_FIXED32: phase = PH_FIXED;
				default: begin
					res = error_word(1'b1, ERR_WIRE_TYPE);
					return 1'b1;
				end
				endcase
				if (eob)
					res = error_word(1'b1, ERR_TRUNCATED);
				return eob;
			end
			endcase
		endfunction

		function void take_byte(in_word_t w);
			out_word_t r;
			if (decode_byte(w, r))
				due_words.push_back(r);
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (due_words.size() == 0) begin
				flag("unexpected word, kind", '0, got.kind);
				return;
			end
			want = due_words.pop_front();
			if (got.kind != want.kind)
				flag("kind", want.kind, got.kind);
			if (got.field_id != want.field_id)
				flag("field_id", want.field_id, got.field_id);
			if (got.wire_fmt != want.wire_fmt)
				flag("wire_fmt", want.wire_fmt, got.wire_fmt);
			if (got.value != want.value)
				flag("value", want.value, got.value);
			if (got.payload_byte != want.payload_byte)
				flag("payload_byte", want.payload_byte, got.payload_byte);
			if (got.payload_last != want.payload_last)
				flag("payload_last", want.payload_last, got.payload_last);
			if (got.error_code != want.error_code)
				flag("error_code", want.error_code, got.error_code);
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	in_word_t  src_word;
	logic      dst_valid;
	logic      dst_stall;
	out_word_t dst_word;

	wire_decode_board board;
	logic [7:0]       msg[$];
	bit               src_steady;
	bit               dst_steady;

	protobuf_field_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word(src_word),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_word(dst_word)
	);

	always #1 clk = ~clk;

	function automatic void push_varint(logic [63:0] v, int pad);
		int          groups;
		logic [63:0] rest;
		rest = v;
		groups = 1;
		while (groups < 10 && (v >> (7 * groups)) != 0)
			groups++;
		groups = (groups + pad > 10) ? 10 : groups + pad;
		for (int i = 0; i < groups; i++) begin
			msg.push_back({i < groups - 1, rest[6:0]});
			rest = rest >> 7;
		end
	endfunction

	function automatic void push_fixed(logic [63:0] v, int n);
		for (int i = 0; i < n; i++)
			msg.push_back(v[8 * i +: 8]);
	endfunction

	task automatic send_msg();
		in_word_t w;
		int       gap;
		for (int i = 0; i < msg.size(); i++) begin
			w.data_byte = msg[i];
			w.end_of_buffer = (i == msg.size() - 1);
			gap = src_steady ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			src_valid <= 1'b1;
			src_word <= w;
			do
				@(posedge clk);
			while (src_stall);
			board.take_byte(w);
		end
		msg.delete();
	endtask

	task automatic drain_results();
		int hold;
		forever begin
			hold = dst_steady ? 0 : $urandom_range(0, 19);
			if (hold > 0) begin
				dst_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			dst_stall <= 1'b0;
			do
				@(posedge clk);
			while (!dst_valid);
			board.check_word(dst_word);
			if ($urandom_range(0, 39) == 0)
				dst_steady = !dst_steady;
		end
	endtask

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int          total;
		int          pick;
		int          pad;
		int          len;
		logic [28:0] fno;
		logic [2:0]  wt;
		logic [31:0] hi;
		logic [63:0] val;
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_word = '0;
		dst_stall = 1'b0;
		src_steady = 1'b0;
		dst_steady = 1'b0;
		total = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drain_results();
		join_none

		msg = '{8'h08, 8'h00};
		send_msg();
		msg = '{8'h0B};
		send_msg();
		msg = '{8'h08};
		send_msg();
		msg = '{8'h08, 8'h80};
		send_msg();
		msg = '{8'h12, 8'h00};
		send_msg();
		msg = '{8'h1A, 8'h01, 8'hFF};
		send_msg();
		msg = '{8'h12, 8'h03, 8'h55};
		send_msg();
		msg = '{8'h12, 8'h03};
		send_msg();
		msg = '{8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h78, 8'h56, 8'h34, 8'h12};
		send_msg();
		repeat (10) msg.push_back(8'h80);
		send_msg();

		while (total < 750) begin
			src_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 11) == 0) begin
				repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					pick = $urandom_range(0, 99);
					case ($urandom_range(0, 3))
					0: fno = 29'($urandom_range(1, 15));
					1: fno = 29'($urandom >> $urandom_range(3, 31));
					2: fno = '1;
					default: fno = 29'($urandom_range(0, 2047));
					endcase
					hi = ($urandom_range(0, 7) == 0) ? $urandom : 32'd0;
					pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
					val = ($urandom_range(0, 9) == 0) ? '1 :
						{$urandom, $urandom} >> $urandom_range(0, 63);
					if (pick < 30)
						wt = WT_VARINT;
					else if (pick < 42)
						wt = WT_FIXED64;
					else if (pick < 54)
						wt = WT_FIXED32;
					else if (pick < 90)
						wt = WT_LEN;
					else if (pick < 95) begin
						do
							wt = 3'($urandom_range(3, 7));
						while (wt == WT_FIXED32);
					end else
						wt = WT_VARINT;
					push_varint({hi, fno, wt}, pad);
					if (pick < 30) begin
						push_varint(val, pad);
					end else if (pick < 54) begin
						push_fixed(val, (wt == WT_FIXED64) ? 8 : 4);
					end else if (pick < 90) begin
						len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
							: $urandom_range(0, 5);
						push_varint(64'(len), pad);
						repeat (len) msg.push_back(8'($urandom));
					end else if (pick >= 95) begin
						repeat ($urandom_range(10, 12)) msg.push_back(8'h80 | 8'($urandom));
					end
				end
				if (msg.size() > 1 && $urandom_range(0, 6) == 0)
					repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
			end
			total += msg.size();
			send_msg();
		end
		src_valid <= 1'b0;

		while (board.due_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.due_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
src/pfd_pkg.sv
src/pfd_front.sv
src/pfd_queue.sv
src/pfd_back.sv
src/protobuf_field_decoder_core.sv
sim/protobuf_field_decoder_core_tb.sv
